// File: hdl/joystick_axis_conditioner_core_assert.svh
// assertion macros for the joystick axis conditioner
// expects clk and rst_n in the scope of the module that uses them
`ifndef JOYSTICK_AXIS_CONDITIONER_CORE_ASSERT_SVH
`define JOYSTICK_AXIS_CONDITIONER_CORE_ASSERT_SVH

// same-cycle implication
`define JAC_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/jac_pkg.sv
// shared types, constants and constant tables of the joystick axis conditioner
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jac_pkg;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } jac_div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } jac_div_rsp_t;

  typedef enum logic [1:0] {
    REG_DEAD_ZONE  = 2'd0,
    REG_EXPONENT   = 2'd1,
    REG_VARIANT    = 2'd2,
    REG_PRESENT    = 2'd3
  } jac_reg_t;

  localparam logic [14:0] DEAD_ZONE_RESET = 15'd4915;
  localparam logic [9:0]  EXPONENT_RESET  = 10'd384;
  localparam logic [16:0] Q15_ONE         = 17'd32768;
  localparam logic [15:0] Q15_MAX         = 16'd32767;
  localparam logic [15:0] PULL_MAX        = 16'd65535;
  localparam logic [15:0] ALT_DIVISOR     = 16'd32767;
  localparam logic [15:0] FIRE_LEVEL      = 16'd6554;
  localparam logic [15:0] AXIS_MIN        = 16'h8000;
  localparam logic [30:0] EXP_ONE         = 31'h4000_0000;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] bt;
    x  = x_in;
    r  = 64'd0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-n) in q0.30, each step the square root of the one before
  function automatic logic [29:0] exp_factor(input int n);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int j = 0; j < n; j++) begin
      c = isqrt64(c << 30);
    end
    return c[29:0];
  endfunction

  localparam logic [29:0] EXP_C [16] = '{
    exp_factor(1),  exp_factor(2),  exp_factor(3),  exp_factor(4),
    exp_factor(5),  exp_factor(6),  exp_factor(7),  exp_factor(8),
    exp_factor(9),  exp_factor(10), exp_factor(11), exp_factor(12),
    exp_factor(13), exp_factor(14), exp_factor(15), exp_factor(16)
  };

endpackage

`default_nettype wire

// File: hdl/jac_if.sv
// valid/ready channel interfaces for event words and result words
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface jac_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [7:0]        event_kind;
  logic [7:0]        event_index;
  logic signed [15:0] event_value;

  modport source (output valid, operation, event_kind, event_index, event_value,
                  input ready);
  modport sink (input valid, operation, event_kind, event_index, event_value,
                output ready);
endinterface

interface jac_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] move_x;
  logic signed [15:0] move_y;
  logic signed [15:0] look_x;
  logic signed [15:0] look_y;
  logic [15:0]        left_pull;
  logic [15:0]        right_pull;
  logic               left_fire;
  logic               right_fire;
  logic               shoulder_left;
  logic               shoulder_right;
  logic               paddle_left;
  logic               paddle_right;

  modport source (output valid, move_x, move_y, look_x, look_y, left_pull,
                  right_pull, left_fire, right_fire, shoulder_left, shoulder_right,
                  paddle_left, paddle_right, input ready);
  modport sink (input valid, move_x, move_y, look_x, look_y, left_pull,
                right_pull, left_fire, right_fire, shoulder_left, shoulder_right,
                paddle_left, paddle_right, output ready);
endinterface

`default_nettype wire

// File: hdl/jac_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on jac_pkg
`timescale 1ns / 1ps
`default_nettype none

module jac_div
  import jac_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire jac_div_req_t req,
  output jac_div_rsp_t      rsp
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [15:0] rem_r;
  logic [31:0] quo_r;
  logic [15:0] div_r;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_r, quo_r[31]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
        rem_r  <= 16'd0;
        quo_r  <= req.dividend;
        div_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? 16'(trial - {1'b0, div_r}) : trial[15:0];
        quo_r <= {quo_r[30:0], fits};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// File: hdl/joystick_axis_conditioner_core.sv
// store word: one per cycle while the sequencer is idle. sample word: the input is ready again
// in the same cycle as the result becomes valid; a stick may take a divider run and the 16-step
// log and 16-step exp loops on the shared multiplier, a camera axis at most a divider run
// device absent: the sample skips conditioning; a held result word stalls the next sample
// synchronous active-low reset clears both stores, the sequencer, the output valid flag and
// the variant and present flags, and loads dead zone 4915 and exponent 384
`timescale 1ns / 1ps
`default_nettype none

`include "joystick_axis_conditioner_core_assert.svh"

module joystick_axis_conditioner_core
  import jac_pkg::*;
#(
  parameter int AXIS_COUNT   = 8,
  parameter int BUTTON_COUNT = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jac_in_if.sink     in_ch,
  jac_out_if.source  out_ch,
  input  wire logic  psel,
  input  wire logic  penable,
  input  wire logic  pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(AXIS_COUNT);
  localparam int BW = $clog2(BUTTON_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_COND, S_DIV, S_LOG_INIT, S_LOG, S_NLOG, S_QMUL, S_EXP_INIT,
    S_EXP, S_EXP_FIN, S_END, S_TRIG, S_DONE
  } state_t;

  state_t      state_r;
  logic [15:0] axis_r [AXIS_COUNT];
  logic        btn_r  [BUTTON_COUNT];
  logic [14:0] dz_r;
  logic [9:0]  exp_r;
  logic        variant_r;
  logic        present_r;

  logic [1:0]  ch_r;
  logic        neg_r;
  logic        zero_r;
  logic [16:0] mag_r;
  logic [15:0] y_r;
  logic [3:0]  lz_r;
  logic [3:0]  step_r;
  logic [15:0] frac_r;
  logic [19:0] n_r;
  logic [21:0] q_r;
  logic [30:0] acc_r;
  logic [15:0] res_r [4];
  logic [15:0] lp_r;
  logic [15:0] rp_r;

  logic        div_start_r;
  logic [31:0] div_dividend_r;
  logic [15:0] div_divisor_r;
  jac_div_req_t div_req;
  jac_div_rsp_t div_rsp;

  logic        out_valid_r;
  logic [15:0] out_move_x_r, out_move_y_r, out_look_x_r, out_look_y_r;
  logic [15:0] out_left_pull_r, out_right_pull_r;
  logic        out_left_fire_r, out_right_fire_r;
  logic        out_shoulder_left_r, out_shoulder_right_r;
  logic        out_paddle_left_r, out_paddle_right_r;

  logic        cfg_wr;
  logic [15:0] raw;
  logic [16:0] mag_in;
  logic [14:0] dz_use;
  logic [16:0] mag_diff;
  logic [3:0]  lead;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [16:0] sq;
  logic [15:0] sat;
  logic [14:0] trig_n;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (jac_reg_t'(paddr[3:2]))
      REG_DEAD_ZONE: prdata = {17'd0, dz_r};
      REG_EXPONENT:  prdata = {22'd0, exp_r};
      REG_VARIANT:   prdata = {31'd0, variant_r};
      REG_PRESENT:   prdata = {31'd0, present_r};
      default:       prdata = 32'd0;
    endcase
  end

  // conditioning front end
  always_comb begin
    case (ch_r)
      2'd0:    raw = axis_r[0];
      2'd1:    raw = axis_r[1];
      2'd2:    raw = axis_r[2];
      default: raw = axis_r[5];
    endcase
  end

  assign mag_in   = raw[15] ? 17'(17'd0 - {1'b1, raw}) : {1'b0, raw};
  assign dz_use   = ch_r[1] ? {1'b0, dz_r[14:1]} : dz_r;
  assign mag_diff = mag_in - {2'b00, dz_use};

  always_comb begin
    lead = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (mag_r[b]) lead = 4'(b);
    end
  end

  // shared multiplier
  always_comb begin
    case (state_r)
      S_LOG:   begin mul_a = {16'd0, y_r};   mul_b = {16'd0, y_r};           end
      S_QMUL:  begin mul_a = {12'd0, n_r};   mul_b = {22'd0, exp_r};         end
      S_EXP:   begin mul_a = {1'b0, acc_r};  mul_b = {2'd0, EXP_C[step_r]};  end
      default: begin mul_a = 32'd0;          mul_b = 32'd0;                  end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign sq     = prod[31:15];
  assign sat    = (mag_r > {1'b0, Q15_MAX}) ? Q15_MAX : mag_r[15:0];
  // low bits of axis 4 plus 32767, valid for negative axis values
  assign trig_n = axis_r[4][14:0] + Q15_MAX[14:0];

  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_dividend_r;
  assign div_req.divisor  = div_divisor_r;

  jac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dz_r        <= DEAD_ZONE_RESET;
      exp_r       <= EXPONENT_RESET;
      variant_r   <= 1'b0;
      present_r   <= 1'b0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      ch_r        <= 2'd0;
      zero_r      <= 1'b0;
      for (int i = 0; i < AXIS_COUNT; i++) axis_r[i] <= 16'd0;
      for (int i = 0; i < BUTTON_COUNT; i++) btn_r[i] <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_ch.valid && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;

      if (cfg_wr) begin
        case (jac_reg_t'(paddr[3:2]))
          REG_DEAD_ZONE: dz_r      <= pwdata[14:0];
          REG_EXPONENT:  exp_r     <= pwdata[9:0];
          REG_VARIANT:   variant_r <= pwdata[0];
          REG_PRESENT:   present_r <= pwdata[0];
          default:       dz_r      <= dz_r;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (!in_ch.operation) begin
              if (in_ch.event_kind[0]) begin
                if (32'(in_ch.event_index) < BUTTON_COUNT)
                  btn_r[in_ch.event_index[BW-1:0]] <= in_ch.event_value[0];
              end else if (in_ch.event_kind[1]) begin
                if (32'(in_ch.event_index) < AXIS_COUNT)
                  axis_r[in_ch.event_index[AW-1:0]] <= in_ch.event_value;
              end
            end else begin
              zero_r  <= !present_r;
              ch_r    <= 2'd0;
              state_r <= present_r ? S_COND : S_DONE;
            end
          end
        end
        S_COND: begin
          neg_r <= raw[15];
          if (mag_in < {2'b00, dz_use}) begin
            mag_r   <= 17'd0;
            state_r <= S_END;
          end else begin
            div_start_r    <= 1'b1;
            div_dividend_r <= 32'(mag_diff) << 15;
            div_divisor_r  <= 16'(Q15_ONE - {2'b00, dz_use});
            state_r        <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            mag_r   <= div_rsp.quotient[16:0];
            state_r <= (!ch_r[1] && div_rsp.quotient != 32'd0) ? S_LOG_INIT : S_END;
          end
        end
        S_LOG_INIT: begin
          y_r     <= 16'(mag_r[15:0] << (4'd15 - lead));
          lz_r    <= 4'd15 - lead;
          step_r  <= 4'd15;
          frac_r  <= 16'd0;
          state_r <= S_LOG;
        end
        S_LOG: begin
          if (sq[16]) begin
            frac_r[step_r] <= 1'b1;
            y_r            <= sq[16:1];
          end else begin
            y_r <= sq[15:0];
          end
          step_r <= step_r - 4'd1;
          if (step_r == 4'd0) state_r <= S_NLOG;
        end
        S_NLOG: begin
          n_r     <= {lz_r, 16'd0} - {4'd0, frac_r};
          state_r <= S_QMUL;
        end
        S_QMUL: begin
          q_r     <= prod[29:8];
          state_r <= S_EXP_INIT;
        end
        S_EXP_INIT: begin
          if (q_r[21:16] > 6'd16) begin
            mag_r   <= 17'd0;
            state_r <= S_END;
          end else begin
            acc_r   <= EXP_ONE;
            step_r  <= 4'd0;
            state_r <= S_EXP;
          end
        end
        S_EXP: begin
          if (q_r[~step_r]) acc_r <= prod[60:30];
          step_r <= step_r + 4'd1;
          if (step_r == 4'd15) state_r <= S_EXP_FIN;
        end
        S_EXP_FIN: begin
          mag_r   <= {1'b0, acc_r[30:15] >> q_r[20:16]};
          state_r <= S_END;
        end
        S_END: begin
          res_r[ch_r] <= neg_r ? 16'(16'd0 - sat) : sat;
          if (ch_r == 2'd3) begin
            state_r <= S_TRIG;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_COND;
          end
        end
        S_TRIG: begin
          if (!variant_r) begin
            lp_r <= axis_r[2] ^ AXIS_MIN;
            rp_r <= axis_r[5] ^ AXIS_MIN;
          end else begin
            // (a + 32767) * 65535 / 32767 saturates for a >= 0, else doubles
            lp_r <= axis_r[3] ^ AXIS_MIN;
            if (axis_r[4] == AXIS_MIN) begin
              rp_r <= 16'd0;
            end else if (!axis_r[4][15]) begin
              rp_r <= PULL_MAX;
            end else begin
              rp_r <= {trig_n, 1'b0};
            end
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r          <= 1'b1;
            out_move_x_r         <= zero_r ? 16'd0 : res_r[0];
            out_move_y_r         <= zero_r ? 16'd0 : res_r[1];
            out_look_x_r         <= zero_r ? 16'd0 : res_r[2];
            out_look_y_r         <= zero_r ? 16'd0 : res_r[3];
            out_left_pull_r      <= zero_r ? 16'd0 : lp_r;
            out_right_pull_r     <= zero_r ? 16'd0 : rp_r;
            out_left_fire_r      <= !zero_r && (lp_r >= FIRE_LEVEL);
            out_right_fire_r     <= !zero_r && (rp_r >= FIRE_LEVEL);
            out_shoulder_left_r  <= !zero_r && btn_r[6];
            out_shoulder_right_r <= !zero_r && btn_r[7];
            out_paddle_left_r    <= !zero_r && btn_r[2];
            out_paddle_right_r   <= !zero_r && btn_r[3];
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.move_x         = out_move_x_r;
  assign out_ch.move_y         = out_move_y_r;
  assign out_ch.look_x         = out_look_x_r;
  assign out_ch.look_y         = out_look_y_r;
  assign out_ch.left_pull      = out_left_pull_r;
  assign out_ch.right_pull     = out_right_pull_r;
  assign out_ch.left_fire      = out_left_fire_r;
  assign out_ch.right_fire     = out_right_fire_r;
  assign out_ch.shoulder_left  = out_shoulder_left_r;
  assign out_ch.shoulder_right = out_shoulder_right_r;
  assign out_ch.paddle_left    = out_paddle_left_r;
  assign out_ch.paddle_right   = out_paddle_right_r;

  `JAC_ASSERT_HOLDS(a_idle_div_free, state_r == S_IDLE, !div_rsp.busy,
    "divider busy while sequencer idle")
  `JAC_ASSERT_HOLDS(a_log_only_sticks, state_r == S_LOG || state_r == S_EXP, !ch_r[1],
    "power curve run on a camera channel")
  `JAC_ASSERT_NEXT(a_store_stays_idle, in_ch.valid && in_ch.ready && !in_ch.operation,
    state_r == S_IDLE, "store word left the idle state")

endmodule

`default_nettype wire

// File: bench/tb_joystick_axis_conditioner_core.sv
// testbench for joystick_axis_conditioner_core: event and sample words in, control words out
// predicts every control word with a scoreboard class; depends on jac_pkg and jac_if
`timescale 1ns / 1ps

module tb_joystick_axis_conditioner_core;
  import jac_pkg::*;

  localparam logic       OP_STORE     = 1'b0;
  localparam logic       OP_SAMPLE    = 1'b1;
  localparam logic [7:0] KIND_NONE    = 8'h00;
  localparam logic [7:0] KIND_BUTTON  = 8'h01;
  localparam logic [7:0] KIND_AXIS    = 8'h02;
  localparam int         N_AXES       = 8;
  localparam int         N_BUTTONS    = 16;
  localparam int         SETTLE       = 300;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         STALL_LIMIT  = 5000;
  localparam int         RANDOM_ITEMS = 1500;

  typedef struct packed {
    logic               op;
    logic [7:0]         kind;
    logic [7:0]         idx;
    logic signed [15:0] val;
  } joy_word_t;

  typedef struct packed {
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [15:0] look_x;
    logic signed [15:0] look_y;
    logic [15:0]        left_pull;
    logic [15:0]        right_pull;
    logic               left_fire;
    logic               right_fire;
    logic               shoulder_left;
    logic               shoulder_right;
    logic               paddle_left;
    logic               paddle_right;
  } controls_t;

  class control_scoreboard;
    logic [15:0] axes[N_AXES];
    logic        buttons[N_BUTTONS];
    int unsigned dead_zone;
    int unsigned exponent;
    bit          alt_triggers;
    bit          present;
    logic [63:0] halving[1:16];
    controls_t   pending[$];
    int          errors;

    function new();
      logic [63:0] c;
      c = 64'd1 << 29;
      for (int i = 1; i <= 16; i++) begin
        c = root64(c << 30);
        halving[i] = c;
      end
      foreach (axes[i]) axes[i] = '0;
      foreach (buttons[i]) buttons[i] = 1'b0;
      dead_zone = 4915;
      exponent = 384;
      alt_triggers = 0;
      present = 0;
      errors = 0;
    endfunction

    function logic [63:0] root64(logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = x_in;
      r = 0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [31:0] minus_log2(logic [31:0] m);
      int          k;
      logic [63:0] y;
      logic [31:0] frac;
      k = 15;
      while (k > 0 && m[k] == 1'b0) k--;
      y = 64'(m) << (15 - k);
      frac = 0;
      for (int i = 15; i >= 0; i--) begin
        y = (y * y) >> 15;
        y = y & 64'hFFFF_FFFF;
        if (y >= 65536) begin
          frac[i] = 1'b1;
          y = y >> 1;
        end
      end
      return 32'((15 - k) * 65536) - frac;
    endfunction

    function logic [31:0] pow2_neg(logic [63:0] q);
      logic [63:0] ip;
      logic [63:0] acc;
      ip = q >> 16;
      acc = 64'd1 << 30;
      if (ip > 16) return 0;
      for (int i = 1; i <= 16; i++) begin
        if (q[16 - i]) acc = (acc * halving[i]) >> 30;
      end
      return 32'((acc >> 15) >> ip);
    endfunction

    function logic [15:0] shape(logic [15:0] raw, int unsigned d, bit curved);
      bit          neg;
      logic [63:0] m;
      neg = raw[15];
      m = neg ? 64'(65536 - raw) : 64'(raw);
      if (m < d) m = 0;
      else m = ((m - d) << 15) / (32768 - d);
      if (curved && m != 0) m = 64'(pow2_neg((64'(minus_log2(m[31:0])) * exponent) >> 8));
      if (m > 32767) m = 32767;
      return neg ? 16'(65536 - m) : m[15:0];
    endfunction

    function void set_reg(jac_reg_t r, logic [31:0] v);
      case (r)
        REG_DEAD_ZONE: dead_zone = v[14:0];
        REG_EXPONENT:  exponent = v[9:0];
        REG_VARIANT:   alt_triggers = v[0];
        REG_PRESENT:   present = v[0];
        default: ;
      endcase
    endfunction

    function void note(joy_word_t w);
      controls_t   o;
      logic [31:0] lp;
      logic [31:0] rp;
      longint      n;
      longint      t;
      if (w.op == OP_STORE) begin
        if (w.kind[0]) begin
          if (w.idx < N_BUTTONS) buttons[w.idx] = w.val[0];
        end else if (w.kind[1]) begin
          if (w.idx < N_AXES) axes[w.idx] = w.val;
        end
        return;
      end
      o = '0;
      if (present) begin
        o.move_x = shape(axes[0], dead_zone, 1);
        o.move_y = shape(axes[1], dead_zone, 1);
        o.look_x = shape(axes[2], dead_zone >> 1, 0);
        o.look_y = shape(axes[5], dead_zone >> 1, 0);
        if (alt_triggers) begin
          lp = $signed(axes[3]) + 32768;
          n = longint'($signed(axes[4])) + 32767;
          if (n < 0) begin
            rp = 0;
          end else begin
            t = (n * 65535) / 32767;
            rp = (t > 65535) ? 32'd65535 : 32'(t);
          end
        end else begin
          lp = $signed(axes[2]) + 32768;
          rp = $signed(axes[5]) + 32768;
        end
        o.left_pull = lp[15:0];
        o.right_pull = rp[15:0];
        o.left_fire = lp * 10 > 65535;
        o.right_fire = rp * 10 > 65535;
        o.shoulder_left = buttons[6];
        o.shoulder_right = buttons[7];
        o.paddle_left = buttons[2];
        o.paddle_right = buttons[3];
      end
      pending.push_back(o);
    endfunction

    function void check(controls_t got);
      controls_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected control word %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.move_x !== want.move_x || got.move_y !== want.move_y ||
          got.look_x !== want.look_x || got.look_y !== want.look_y ||
          got.left_pull !== want.left_pull || got.right_pull !== want.right_pull ||
          got.left_fire !== want.left_fire || got.right_fire !== want.right_fire ||
          got.shoulder_left !== want.shoulder_left ||
          got.shoulder_right !== want.shoulder_right ||
          got.paddle_left !== want.paddle_left || got.paddle_right !== want.paddle_right) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  jac_in_if  in_ch();
  jac_out_if out_ch();

  control_scoreboard board = new();
  int  tx_idle = 13;
  int  rx_idle = 52;
  bit  hold_req = 0;
  int  hold_cnt = 0;
  int  quiet = 0;

  always #5 clk = ~clk;

  joystick_axis_conditioner_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_STORE;
    in_ch.event_kind = KIND_NONE;
    in_ch.event_index = '0;
    in_ch.event_value = '0;
    out_ch.ready = 1'b0;
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) hold_cnt <= HOLD_CYCLES;
    if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) hold_req <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check('{out_ch.move_x, out_ch.move_y, out_ch.look_x, out_ch.look_y,
                    out_ch.left_pull, out_ch.right_pull, out_ch.left_fire,
                    out_ch.right_fire, out_ch.shoulder_left, out_ch.shoulder_right,
                    out_ch.paddle_left, out_ch.paddle_right});
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(jac_reg_t r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    board.set_reg(r, v);
  endtask

  task automatic send(logic op, logic [7:0] kind, logic [7:0] idx, logic [15:0] val);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.event_kind <= kind;
    in_ch.event_index <= idx;
    in_ch.event_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    board.note('{op, kind, idx, val});
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h8001;
      3: return 16'(board.dead_zone + $urandom_range(4) - 2);
      4: return 16'(-int'(board.dead_zone) + $urandom_range(4) - 2);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_item();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) begin
      send(OP_STORE, KIND_AXIS, 8'($urandom_range(N_AXES - 1)), pick_value());
    end else if (roll < 62) begin
      send(OP_STORE, KIND_BUTTON, 8'($urandom_range(N_BUTTONS - 1)), 16'($urandom()));
    end else if (roll < 85) begin
      send(OP_SAMPLE, 8'($urandom()), 8'($urandom()), 16'($urandom()));
    end else begin
      send(OP_STORE, 8'($urandom()), 8'($urandom()), 16'($urandom()));
    end
  endtask

  initial begin
    int dz_set[5];
    int exp_set[5];
    int part;
    dz_set  = '{0, 16384, 4915, 32767, 1000};
    exp_set = '{128, 768, 384, 0, 1023};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // device absent, then reset settings
    send(OP_STORE, KIND_AXIS, 0, 16'h7FFF);
    send(OP_SAMPLE, 8'hFF, 8'hFF, 16'hFFFF);
    drain();
    write_reg(REG_PRESENT, 32'd1);
    send(OP_STORE, KIND_AXIS, 1, 16'h8000);
    send(OP_STORE, KIND_AXIS, 2, 16'h0000);
    send(OP_STORE, KIND_AXIS, 5, 16'h8001);
    send(OP_STORE, KIND_AXIS, 3, 16'h7FFF);
    send(OP_STORE, KIND_AXIS, 4, 16'h8000);
    send(OP_STORE, KIND_BUTTON, 6, 16'h0001);
    send(OP_STORE, 8'h03, 7, 16'hFFFF);
    send(OP_STORE, KIND_BUTTON, 2, 16'h0003);
    send(OP_STORE, KIND_BUTTON, 3, 16'hFFFE);
    send(OP_SAMPLE, '0, '0, '0);
    send(OP_STORE, KIND_AXIS, 8, 16'h1234);
    send(OP_STORE, KIND_BUTTON, 16, 16'h0000);
    send(OP_STORE, KIND_AXIS, 8'hFF, 16'h4321);
    send(OP_STORE, KIND_NONE, 0, 16'h0000);
    send(OP_STORE, 8'hFC, 1, 16'h0000);
    send(OP_SAMPLE, '0, '0, '0);
    drain();
    write_reg(REG_VARIANT, 32'd1);
    send(OP_SAMPLE, '0, '0, '0);
    drain();

    for (int s = 0; s < 5; s++) begin
      write_reg(REG_DEAD_ZONE, dz_set[s]);
      write_reg(REG_EXPONENT, exp_set[s]);
      write_reg(REG_VARIANT, s % 2);
      write_reg(REG_PRESENT, 32'(s != 4 || $urandom_range(1)));
      for (int k = 0; k < RANDOM_ITEMS / 5; k++) begin
        part = (s * (RANDOM_ITEMS / 5) + k) * 3 / RANDOM_ITEMS;
        if (part == 0) begin
          tx_idle = 13;
          rx_idle = 52;
        end else if (part == 1) begin
          tx_idle = 52;
          rx_idle = 13;
        end else begin
          tx_idle = 0;
          rx_idle = 0;
        end
        if (s == 4 && k == 10) hold_req = 1;
        random_item();
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
